// File: rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("port check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

// File: rtl/lrupr_pkg.sv
// shared types, widths and helpers for the lru page table
package lrupr_pkg;

  localparam int PAGE_W          = 20;
  localparam int AGE_W           = 5;
  localparam int WAYS_W          = 5;
  localparam int SLOT_W          = 4;
  localparam int COUNT_W         = 32;
  localparam int MAX_SLOTS_DEF   = 16;
  localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
    logic [AGE_W-1:0]  age;
  } entry_t;

  typedef struct packed {
    logic   en;
    entry_t data;
  } wr_req_t;

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    age_inc = (a == AGE_MAX) ? a : a + AGE_W'(1);
  endfunction

  function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] c);
    count_inc = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

endpackage

// File: rtl/lrupr_table.sv
// slot memory with registered read and per-entry written flags
module lrupr_table #(
  parameter int DEPTH = lrupr_pkg::MAX_SLOTS_DEF,
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic [IDX_W-1:0]     wr_addr,
  input  lrupr_pkg::wr_req_t   wr,
  output lrupr_pkg::entry_t    rd_entry
);
  import lrupr_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] written;
  entry_t           rd_q;
  logic             rd_written;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    rd_q <= mem[rd_addr];
  end

  // flags clear at reset so untouched entries read as empty and age zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr_addr] <= 1'b1;
      end
      rd_written <= written[rd_addr];
    end
  end

  always_comb begin
    rd_entry = rd_q;
    if (!rd_written) begin
      rd_entry.valid = 1'b0;
      rd_entry.age   = '0;
    end
  end

endmodule

// File: rtl/lru_page_replacement.sv
// top level of the lru page table with age-counter replacement
//
// Fully associative page table of MAX_SLOTS slots, of which the first ways_in_use
// are active (a write of 0 counts as 1, anything above MAX_SLOTS as MAX_SLOTS).
// Every slot keeps valid, page and a 5-bit saturating age in one synchronous
// memory with one read port and one write port. A request goes through two
// passes over the active slots,
// one memory read a cycle: the first looks for the lowest valid slot holding the
// page, the second reads, ages and writes back every slot and, on a fault, picks
// the oldest slot (lowest index on ties). A fault then writes the new page into
// that slot with age zero. One request is worked on at a time; the result sits in an
// output register, so the next request is taken while it waits. The request and
// fault counts saturate at all ones. Configuration is written through cfg_write
// and cfg_data and is meant to take effect for the next request: the user is to
// write it only between requests, as the block itself does not enforce this.
module lru_page_replacement #(
  parameter int MAX_SLOTS = lrupr_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lrupr_pkg::WAYS_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lrupr_pkg::PAGE_W-1:0]  page_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [lrupr_pkg::SLOT_W-1:0]  slot,
  output logic [lrupr_pkg::COUNT_W-1:0] request_count,
  output logic [lrupr_pkg::COUNT_W-1:0] fault_count
);
  import lrupr_pkg::*;

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int EXT_W = (CNT_W > WAYS_W) ? CNT_W : WAYS_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_AGE  = 5'b00100,
    ST_FILL = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   active;       // clamped number of active slots
  logic [CNT_W-1:0]   rd_cnt;       // next slot to read in the current pass
  logic               rd_pend;      // read data for rd_slot arrives this cycle
  logic [IDX_W-1:0]   rd_slot;
  logic [PAGE_W-1:0]  req_page;
  logic               found;
  logic [IDX_W-1:0]   hit_idx;
  logic [AGE_W-1:0]   hit_age;
  logic [IDX_W-1:0]   chosen;       // fault victim
  logic [AGE_W-1:0]   oldest;
  logic [COUNT_W-1:0] requests_seen;
  logic [COUNT_W-1:0] faults_seen;

  logic               issue;
  logic [IDX_W-1:0]   wr_addr;
  wr_req_t            wr;
  entry_t             rd_entry;
  logic [AGE_W-1:0]   new_age;
  logic               load_out;
  logic [IDX_W-1:0]   res_idx;
  logic [SLOT_W+IDX_W-1:0] res_ext;
  logic [EXT_W-1:0]   cfg_ext;
  logic [EXT_W-1:0]   cfg_clamped;

  lrupr_table #(
    .DEPTH (MAX_SLOTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_cnt[IDX_W-1:0]),
    .wr_addr  (wr_addr),
    .wr       (wr),
    .rd_entry (rd_entry)
  );

  // ways_in_use clamped once at write time
  always_comb begin
    cfg_ext = EXT_W'(cfg_data);
    if (cfg_data == '0) begin
      cfg_clamped = EXT_W'(1);
    end else if (cfg_ext > EXT_W'(MAX_SLOTS)) begin
      cfg_clamped = EXT_W'(MAX_SLOTS);
    end else begin
      cfg_clamped = cfg_ext;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign issue    = ((state == ST_SCAN) || (state == ST_AGE)) && (rd_cnt < active);
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  // age update for the entry coming back in the second pass
  always_comb begin
    if (found) begin
      if (rd_slot == hit_idx) begin
        new_age = '0;
      end else if (rd_entry.age < hit_age) begin
        new_age = age_inc(rd_entry.age);
      end else begin
        new_age = rd_entry.age;
      end
    end else begin
      new_age = age_inc(rd_entry.age);
    end
  end

  // write port: aged write-back in the second pass, page refill after a fault
  always_comb begin
    wr      = '0;
    wr_addr = rd_slot;
    case (state)
      ST_AGE: begin
        wr.en         = rd_pend;
        wr.data.valid = rd_entry.valid;
        wr.data.page  = rd_entry.page;
        wr.data.age   = new_age;
      end
      ST_FILL: begin
        wr_addr       = chosen;
        wr.en         = 1'b1;
        wr.data.valid = 1'b1;
        wr.data.page  = req_page;
        wr.data.age   = '0;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  assign res_idx = found ? hit_idx : chosen;
  assign res_ext = {SLOT_W'(0), res_idx};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active        <= CNT_W'(MAX_SLOTS);
      rd_cnt        <= '0;
      rd_pend       <= 1'b0;
      found         <= 1'b0;
      requests_seen <= '0;
      faults_seen   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        active <= CNT_W'(cfg_clamped);
      end
      rd_pend <= issue;
      if (issue) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            found  <= 1'b0;
            rd_cnt <= '0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_pend && !found && rd_entry.valid && (rd_entry.page == req_page)) begin
            found <= 1'b1;
          end
          // last read data is in this cycle
          if (!issue) begin
            rd_cnt <= '0;
            state  <= ST_AGE;
          end
        end
        ST_AGE: begin
          if (!issue) begin
            requests_seen <= count_inc(requests_seen);
            if (!found) begin
              faults_seen <= count_inc(faults_seen);
              state       <= ST_FILL;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_FILL: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_page <= page_number;
    end
    if (issue) begin
      rd_slot <= rd_cnt[IDX_W-1:0];
    end
    // first matching slot wins
    if ((state == ST_SCAN) && rd_pend && !found && rd_entry.valid
        && (rd_entry.page == req_page)) begin
      hit_idx <= rd_slot;
      hit_age <= rd_entry.age;
    end
    // oldest aged slot, strict compare keeps the lowest index on ties
    if ((state == ST_AGE) && rd_pend && !found
        && ((rd_slot == '0) || (new_age > oldest))) begin
      oldest <= new_age;
      chosen <= rd_slot;
    end
    if (load_out) begin
      hit           <= found;
      slot          <= res_ext[SLOT_W-1:0];
      request_count <= requests_seen;
      fault_count   <= faults_seen;
    end
  end

endmodule

// File: rtl/lrupr_checker.sv
// port-level checks for the lru page table, bound to the top level
`include "assert_macros.svh"

module lrupr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          hit,
  input logic [lrupr_pkg::SLOT_W-1:0]  slot,
  input logic [lrupr_pkg::COUNT_W-1:0] request_count,
  input logic [lrupr_pkg::COUNT_W-1:0] fault_count
);
  import lrupr_pkg::*;

  logic [1:0]         pending;
  logic               seen_one;
  logic [COUNT_W-1:0] prev_req;
  logic [COUNT_W-1:0] prev_fault;
  logic               in_beat;
  logic               out_beat;
  logic [COUNT_W-1:0] req_next;
  logic [SLOT_W+2*COUNT_W:0] res_bits;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;
  assign req_next = prev_req + COUNT_W'(1);
  assign res_bits = {hit, slot, request_count, fault_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      seen_one <= 1'b0;
    end else begin
      case ({in_beat, out_beat})
        2'b10:   pending <= pending + 2'd1;
        2'b01:   pending <= pending - 2'd1;
        default: pending <= pending;
      endcase
      if (out_beat) begin
        seen_one <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      prev_req   <= request_count;
      prev_fault <= fault_count;
    end
  end

  // a stalled result beat holds
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_bits))
  // no result without an accepted request
  `CHK_IMP(a_no_spurious, out_valid, pending != 2'd0)
  // each result counts exactly one more request until saturation
  `CHK_IMP(a_req_step, out_valid && seen_one && (prev_req != COUNT_MAX), request_count == req_next)
  // a hit leaves the fault count alone
  `CHK_IMP(a_hit_no_fault, out_valid && seen_one && hit, fault_count == prev_fault)

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the lru page table: directed and random page references

module testbench;
  import lrupr_pkg::*;

  localparam int SLOTS = MAX_SLOTS_DEF;

  // ways settings for the random phases, the last two phases draw their own
  localparam int WAYS_PLAN [10] = '{16, 1, 0, 31, 2, 8, 17, 4, 12, 16};
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 100;

  // one lookup outcome as the block reports it
  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] requests;
    logic [COUNT_W-1:0] faults;
  } lookup_t;

  // scoreboard: keeps its own copy of the page table and predicts each lookup
  class page_table_scoreboard;
    logic [WAYS_W-1:0]  ways_reg;
    logic [PAGE_W-1:0]  page_of [SLOTS];
    logic               held [SLOTS];
    logic [AGE_W-1:0]   age_of [SLOTS];
    logic [COUNT_W-1:0] requests;
    logic [COUNT_W-1:0] faults;
    lookup_t            awaited_lookups [$];
    int                 mismatches;

    function new();
      ways_reg = WAYS_W'(SLOTS);
      requests = '0;
      faults = '0;
      mismatches = 0;
      foreach (held[i]) begin
        held[i] = 1'b0;
        age_of[i] = '0;
        page_of[i] = '0;
      end
    endfunction

    function void set_ways(logic [WAYS_W-1:0] w);
      ways_reg = w;
    endfunction

    function int pending();
      return awaited_lookups.size();
    endfunction

    // a zero setting behaves as one slot, anything too big as the full table
    function int active_ways();
      if (ways_reg == 0) return 1;
      if (ways_reg > SLOTS) return SLOTS;
      return int'(ways_reg);
    endfunction

    function logic [AGE_W-1:0] older(logic [AGE_W-1:0] a);
      return (a == '1) ? a : a + AGE_W'(1);
    endfunction

    function lookup_t predict_lookup(logic [PAGE_W-1:0] p);
      int n;
      int chosen;
      logic found;
      logic [AGE_W-1:0] hit_age;
      logic [AGE_W-1:0] oldest;
      lookup_t r;
      n = active_ways();
      found = 1'b0;
      chosen = 0;
      if (requests != '1) requests = requests + 1;
      // lowest valid active slot holding the page wins
      for (int s = 0; s < n; s++) begin
        if (!found && held[s] && page_of[s] == p) begin
          chosen = s;
          found = 1'b1;
        end
      end
      if (found) begin
        hit_age = age_of[chosen];
        for (int s = 0; s < n; s++) begin
          if (age_of[s] < hit_age) age_of[s] = older(age_of[s]);
        end
        age_of[chosen] = '0;
      end else begin
        if (faults != '1) faults = faults + 1;
        for (int s = 0; s < n; s++) age_of[s] = older(age_of[s]);
        // oldest active slot, lowest index on ties, takes the page
        oldest = age_of[0];
        chosen = 0;
        for (int s = 1; s < n; s++) begin
          if (age_of[s] > oldest) begin
            oldest = age_of[s];
            chosen = s;
          end
        end
        page_of[chosen] = p;
        held[chosen] = 1'b1;
        age_of[chosen] = '0;
      end
      r.hit = found;
      r.slot = SLOT_W'(chosen);
      r.requests = requests;
      r.faults = faults;
      return r;
    endfunction

    function void note_request(logic [PAGE_W-1:0] p);
      awaited_lookups.push_back(predict_lookup(p));
    endfunction

    function void check_result(lookup_t got);
      lookup_t want;
      if (awaited_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: hit %0d slot %0d requests %0d faults %0d",
                   got.hit, got.slot, got.requests, got.faults);
        return;
      end
      want = awaited_lookups.pop_front();
      if (got.hit !== want.hit || got.slot !== want.slot ||
          got.requests !== want.requests || got.faults !== want.faults) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want hit %0d slot %0d requests %0d faults %0d, got hit %0d slot %0d requests %0d faults %0d",
                   want.hit, want.slot, want.requests, want.faults,
                   got.hit, got.slot, got.requests, got.faults);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [WAYS_W-1:0]  cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PAGE_W-1:0]  page_number = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               hit;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] request_count;
  logic [COUNT_W-1:0] fault_count;

  // quiet flags switch off the idle gaps on one side for a whole phase
  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;

  page_table_scoreboard sb = new();

  always #2 clk = ~clk;

  lru_page_replacement dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page_number   (page_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .slot          (slot),
    .request_count (request_count),
    .fault_count   (fault_count)
  );

  // result beats are sampled on the rising edge, inputs only move on the falling one
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(lookup_t'{hit, slot, request_count, fault_count});
  end

  // offer one page reference, after a random gap unless the phase is quiet;
  // valid is left high on return so back-to-back beats never drop it
  task automatic send_page(input logic [PAGE_W-1:0] p);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    page_number = p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(p);
    @(negedge clk);
  endtask

  // hold off the sender until every awaited result beat has come back
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // the block is idle once nothing is awaited: every reference gives one result
  task automatic write_ways(input logic [WAYS_W-1:0] w);
    wait_for_results();
    cfg_write = 1'b1;
    cfg_data = w;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.set_ways(w);
  endtask

  // receiver: random stall before each result beat, none in quiet phases
  initial begin
    int stall;
    while (rst) @(negedge clk);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    logic [PAGE_W-1:0] pool [32];
    int pool_n;
    int eff;
    int w;
    logic [PAGE_W-1:0] p;

    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, empty slots filling in order, hits
    write_ways(WAYS_W'(16));
    send_page('0);
    send_page('1);
    send_page('0);
    send_page('1);
    send_page(PAGE_W'('h5A5A5));
    send_page(PAGE_W'('hA5A5A));
    send_page(PAGE_W'('h5A5A5));

    // a single slot: only slot 0 is looked at, the rest keep their pages
    write_ways(WAYS_W'(1));
    send_page('1);
    send_page('1);
    send_page('0);

    // zero ways behaves as one
    write_ways(WAYS_W'(0));
    send_page('0);
    send_page('1);

    // too many ways behaves as the full table; slots 0 and 1 now both hold
    // the all-ones page so the lowest index must be hit
    write_ways('1);
    send_page('1);
    send_page(PAGE_W'('hA5A5A));
    send_page(PAGE_W'('h5A5A5));
    send_page(PAGE_W'('h00001));
    send_page(PAGE_W'('h80000));
    send_page('0);

    // random phases, each with its own ways setting and a working set of pages
    // a little larger than the active slots so that hits and faults both occur
    foreach (pool[i]) pool[i] = PAGE_W'($urandom());
    for (int ph = 0; ph < PHASES; ph++) begin
      w = (ph < 10) ? WAYS_PLAN[ph] : $urandom_range(0, 31);
      write_ways(WAYS_W'(w));
      eff = (w == 0) ? 1 : (w > SLOTS) ? SLOTS : w;
      pool_n = eff + $urandom_range(0, eff / 2 + 2);
      // keep part of the old working set so retained pages get hit again
      for (int i = 0; i < pool_n; i++) begin
        if ($urandom_range(0, 3) == 0)
          pool[i] = $urandom_range(0, 1) ? PAGE_W'($urandom_range(0, 63))
                                         : PAGE_W'($urandom());
      end
      tx_quiet = (ph % 3 == 1);
      rx_quiet = (ph % 3 == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 85)
          p = pool[$urandom_range(0, pool_n - 1)];
        else
          p = PAGE_W'($urandom());
        send_page(p);
        if ($urandom_range(0, 59) == 0) wait_for_results();
      end
    end

    // drain, then allow a full request's latency for any stray beat
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    wait_for_results();
    repeat (60) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/lrupr_pkg.sv
rtl/lrupr_table.sv
rtl/lru_page_replacement.sv
rtl/lrupr_checker.sv
test/testbench.sv
